// ===== rtl/deadband_quadratic_gain_pd_steer_defines.svh =====
// Assertion helpers for the steering controller.
`ifndef DEADBAND_QUADRATIC_GAIN_PD_STEER_DEFINES_SVH
`define DEADBAND_QUADRATIC_GAIN_PD_STEER_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define DQGPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dqgps: implication check failed");

// Next-cycle implication, quiet during reset.
`define DQGPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dqgps: next-cycle check failed");

`endif

// ===== rtl/dqgps_pkg.sv =====
package dqgps_pkg;

  localparam int unsigned STEP_W      = 4;
  localparam int unsigned POINT_RIGHT = 70;
  localparam int unsigned POINT_LEFT  = 10;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    REG_CENTER = 3'd0,
    REG_LEFT   = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_DBAND  = 3'd3,
    REG_BASE   = 3'd4,
    REG_QUAD   = 3'd5,
    REG_DIFF   = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic [2:0] {
    OP_EXCESS,
    OP_MUL,
    OP_KP_ADD,
    OP_KP_BASE,
    OP_SUM,
    OP_CORR,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    A_X,
    A_QUAD,
    A_KP,
    A_DIFF
  } a_sel_e;

  typedef enum logic [1:0] {
    B_X,
    B_P,
    B_E,
    B_DE
  } b_sel_e;

  typedef enum logic {
    DST_P,
    DST_ACC
  } dst_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_INBAND,
    JMP_ALWAYS
  } jmp_e;

  typedef struct packed {
    op_e    op;
    a_sel_e a_sel;
    b_sel_e b_sel;
    dst_e   dst;
    jmp_e   jmp;
    step_t  target;
  } ctrl_t;

  typedef struct packed {
    logic [15:0] center;
    logic [15:0] left;
    logic [15:0] right;
    logic [6:0]  dband;
    logic [23:0] base;
    logic [23:0] quad;
    logic [23:0] diff;
  } cfg_t;

  localparam step_t STEP_EXCESS  = 4'd0;
  localparam step_t STEP_SQ      = 4'd1;
  localparam step_t STEP_QMUL    = 4'd2;
  localparam step_t STEP_KP_ADD  = 4'd3;
  localparam step_t STEP_KP_BASE = 4'd4;
  localparam step_t STEP_PMUL    = 4'd5;
  localparam step_t STEP_DMUL    = 4'd6;
  localparam step_t STEP_SUM     = 4'd7;
  localparam step_t STEP_CORR    = 4'd8;
  localparam step_t STEP_OUT     = 4'd9;

  function automatic ctrl_t rom(input step_t s);
    ctrl_t c;
    c.op     = OP_OUT;
    c.a_sel  = A_X;
    c.b_sel  = B_X;
    c.dst    = DST_P;
    c.jmp    = JMP_NONE;
    c.target = STEP_EXCESS;
    unique case (s)
      STEP_EXCESS: begin
        c.op     = OP_EXCESS;
        c.jmp    = JMP_INBAND;
        c.target = STEP_KP_BASE;
      end
      STEP_SQ: begin
        c.op    = OP_MUL;
        c.a_sel = A_X;
        c.b_sel = B_X;
      end
      STEP_QMUL: begin
        c.op    = OP_MUL;
        c.a_sel = A_QUAD;
        c.b_sel = B_P;
      end
      STEP_KP_ADD: begin
        c.op     = OP_KP_ADD;
        c.jmp    = JMP_ALWAYS;
        c.target = STEP_PMUL;
      end
      STEP_KP_BASE: c.op = OP_KP_BASE;
      STEP_PMUL: begin
        c.op    = OP_MUL;
        c.a_sel = A_KP;
        c.b_sel = B_E;
        c.dst   = DST_ACC;
      end
      STEP_DMUL: begin
        c.op    = OP_MUL;
        c.a_sel = A_DIFF;
        c.b_sel = B_DE;
      end
      STEP_SUM:  c.op = OP_SUM;
      STEP_CORR: c.op = OP_CORR;
      default:   c.op = OP_OUT;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/deadband_quadratic_gain_pd_steer.sv =====
// Steering servo PD controller with scheduled proportional gain.
// Input stream: one word per camera frame, lateral error and track point.
// Output stream: one servo duty word per input word, in order.
// Config channel: register index and data, always ready; write only while
// the block is idle.
// A short microprogram in a constant table runs the datapath, one step a
// cycle except while the last step waits for the output register; a
// conditional jump skips the quadratic term when the error is inside the
// dead band. The step count is set by the single shared multiplier, used
// up to four times per word. The next word is taken the cycle after the
// result is registered.
// The output register holds a finished duty while the receiver stalls; the
// next word may run meanwhile and waits in its last step until the register
// frees.
// Reset clears the sequencer, output valid, previous error and restores the
// register defaults (right duty 65535, dead band 7, all else zero).
`include "deadband_quadratic_gain_pd_steer_defines.svh"

module deadband_quadratic_gain_pd_steer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] lateral_error, [15:8] track_point
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] servo_duty
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [23:0] cfg_data_i
);

  dqgps_pkg::cfg_t   cfg_q;
  dqgps_pkg::state_e st_q, st_d;
  dqgps_pkg::step_t  step_q, step_d;
  dqgps_pkg::ctrl_t  ctrl;
  logic              m_valid_q, m_valid_d;
  logic [15:0]       m_data_q;
  logic              out_free;
  logic              fire;
  logic              accept;
  logic              out_fire;
  logic              inband;
  logic [15:0]       duty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center <= 16'd0;
      cfg_q.left   <= 16'd0;
      cfg_q.right  <= 16'hFFFF;
      cfg_q.dband  <= 7'd7;
      cfg_q.base   <= 24'd0;
      cfg_q.quad   <= 24'd0;
      cfg_q.diff   <= 24'd0;
    end else if (cfg_valid_i) begin
      unique case (dqgps_pkg::cfg_idx_e'(cfg_addr_i))
        dqgps_pkg::REG_CENTER: cfg_q.center <= cfg_data_i[15:0];
        dqgps_pkg::REG_LEFT:   cfg_q.left   <= cfg_data_i[15:0];
        dqgps_pkg::REG_RIGHT:  cfg_q.right  <= cfg_data_i[15:0];
        dqgps_pkg::REG_DBAND:  cfg_q.dband  <= cfg_data_i[6:0];
        dqgps_pkg::REG_BASE:   cfg_q.base   <= cfg_data_i;
        dqgps_pkg::REG_QUAD:   cfg_q.quad   <= cfg_data_i;
        dqgps_pkg::REG_DIFF:   cfg_q.diff   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ctrl     = dqgps_pkg::rom(step_q);
  assign out_free = !m_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_fire = fire && ctrl.op == dqgps_pkg::OP_OUT;

  // next state
  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    unique case (st_q)
      dqgps_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          st_d   = dqgps_pkg::ST_RUN;
          step_d = dqgps_pkg::STEP_EXCESS;
        end
      end
      dqgps_pkg::ST_RUN: begin
        if (fire) begin
          priority if (ctrl.op == dqgps_pkg::OP_OUT) begin
            st_d = dqgps_pkg::ST_IDLE;
          end else if (ctrl.jmp == dqgps_pkg::JMP_ALWAYS ||
                       (ctrl.jmp == dqgps_pkg::JMP_INBAND && inband)) begin
            step_d = ctrl.target;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: st_d = dqgps_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    fire          = 1'b0;
    unique case (st_q)
      dqgps_pkg::ST_IDLE: s_axis_tready = 1'b1;
      dqgps_pkg::ST_RUN:  fire = (ctrl.op != dqgps_pkg::OP_OUT) || out_free;
      default: ;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_fire)           m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= dqgps_pkg::ST_IDLE;
      step_q    <= dqgps_pkg::STEP_EXCESS;
      m_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      step_q    <= step_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) m_data_q <= duty;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  dqgps_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .ctrl_i   (ctrl),
    .en_i     (fire),
    .load_i   (accept),
    .err_i    (s_axis_tdata[7:0]),
    .point_i  (s_axis_tdata[15:8]),
    .inband_o (inband),
    .duty_o   (duty)
  );

  `DQGPS_ASSERT_NXT(a_accept_starts, accept,
                    st_q == dqgps_pkg::ST_RUN && step_q == dqgps_pkg::STEP_EXCESS)
  `DQGPS_ASSERT_IMP(a_step_range, st_q == dqgps_pkg::ST_RUN,
                    step_q <= dqgps_pkg::STEP_OUT)
  `DQGPS_ASSERT_IMP(a_valid_from_out, $rose(m_axis_tvalid), $past(out_fire))

endmodule

// ===== rtl/dqgps_datapath.sv =====
module dqgps_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dqgps_pkg::cfg_t   cfg_i,
  input  dqgps_pkg::ctrl_t  ctrl_i,
  input  logic              en_i,
  input  logic              load_i,
  input  logic [7:0]        err_i,
  input  logic [7:0]        point_i,
  output logic              inband_o,
  output logic [15:0]       duty_o
);

  logic signed [7:0]  e_q;
  logic [7:0]         tp_q;
  logic signed [7:0]  prev_q;
  logic [7:0]         x_q;
  logic signed [49:0] p_q;
  logic [39:0]        kp_q;
  logic signed [49:0] acc_q;

  logic [8:0]         neg_e;
  logic [7:0]         mag;
  logic signed [8:0]  de;
  logic signed [40:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [56:0] mul_p;
  logic               acc_neg;
  logic [49:0]        acc_mag;
  logic [33:0]        quo;
  logic signed [35:0] corr_s;
  logic signed [36:0] duty_s;
  logic [16:0]        d17;
  logic [16:0]        lo;
  logic [16:0]        hi;

  assign neg_e    = 9'd0 - {e_q[7], e_q};
  assign mag      = e_q[7] ? neg_e[7:0] : e_q;
  assign inband_o = mag <= {1'b0, cfg_i.dband};
  assign de       = $signed({e_q[7], e_q}) - $signed({prev_q[7], prev_q});

  always_comb begin
    unique case (ctrl_i.a_sel)
      dqgps_pkg::A_X:    mul_a = $signed({33'd0, x_q});
      dqgps_pkg::A_QUAD: mul_a = $signed({17'd0, cfg_i.quad});
      dqgps_pkg::A_KP:   mul_a = $signed({1'b0, kp_q});
      default:           mul_a = $signed({17'd0, cfg_i.diff});
    endcase
    unique case (ctrl_i.b_sel)
      dqgps_pkg::B_X: mul_b = $signed({8'd0, x_q});
      dqgps_pkg::B_P: mul_b = $signed({1'b0, p_q[14:0]});
      dqgps_pkg::B_E: mul_b = $signed({{8{e_q[7]}}, e_q});
      default:        mul_b = $signed({{7{de[8]}}, de});
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // truncation toward zero of the Q16 sum
  assign acc_neg = acc_q[49];
  assign acc_mag = acc_neg ? 50'(-acc_q) : acc_q;
  assign quo     = acc_mag[49:16];
  assign corr_s  = acc_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});

  assign duty_s = $signed({21'd0, cfg_i.center}) - $signed(acc_q[36:0]);

  always_comb begin
    lo = (cfg_i.left < cfg_i.right) ? {1'b0, cfg_i.left}  : {1'b0, cfg_i.right};
    hi = (cfg_i.left < cfg_i.right) ? {1'b0, cfg_i.right} : {1'b0, cfg_i.left};
    priority if (duty_s[36]) begin
      d17 = 17'd0;
    end else if (|duty_s[35:16]) begin
      d17 = 17'h10000;
    end else begin
      d17 = {1'b0, duty_s[15:0]};
    end
    if (tp_q > 8'(dqgps_pkg::POINT_RIGHT)) d17 = {1'b0, cfg_i.right};
    if (tp_q < 8'(dqgps_pkg::POINT_LEFT))  d17 = {1'b0, cfg_i.left};
    if (d17 < lo) d17 = lo;
    if (d17 > hi) d17 = hi;
    duty_o = d17[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (en_i && ctrl_i.op == dqgps_pkg::OP_OUT) begin
      prev_q <= e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      e_q  <= $signed(err_i);
      tp_q <= point_i;
    end
    if (en_i) begin
      unique case (ctrl_i.op)
        dqgps_pkg::OP_EXCESS:  x_q  <= mag - {1'b0, cfg_i.dband};
        dqgps_pkg::OP_MUL: begin
          if (ctrl_i.dst == dqgps_pkg::DST_ACC) acc_q <= mul_p[49:0];
          else                                  p_q   <= mul_p[49:0];
        end
        dqgps_pkg::OP_KP_ADD:  kp_q  <= {16'd0, cfg_i.base} + {1'b0, p_q[38:0]};
        dqgps_pkg::OP_KP_BASE: kp_q  <= {16'd0, cfg_i.base};
        dqgps_pkg::OP_SUM:     acc_q <= acc_q + p_q + 50'sd32768;
        dqgps_pkg::OP_CORR:    acc_q <= {{14{corr_s[35]}}, corr_s};
        default: ;
      endcase
    end
  end

endmodule

// ===== bench/tb_deadband_quadratic_gain_pd_steer.sv =====
`timescale 1ns / 100ps

module tb_deadband_quadratic_gain_pd_steer;

  localparam int          NUM_REG_SLOTS  = 8;
  localparam logic [2:0]  REG_UNUSED     = 3'd7;
  localparam longint      HALF_LSB       = 32768;
  localparam longint      Q16_ONE        = 65536;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          RAND_PHASES    = 8;
  localparam int          WORDS_PER_PHASE = 200;
  localparam int          PHASE_SWAPPED  = 1;
  localparam int          PHASE_ALL_ONES = 2;
  localparam int          PHASE_ALL_ZERO = 3;
  localparam int          STALL_AT_WORD  = 30;
  localparam int          STALL_CYCLES   = 400;
  localparam int          NUM_DIRECTED   = 20;

  localparam int DIR_ERR [NUM_DIRECTED] = '{0, 7, -7, 8, -8, 127, -128, 127, -100, 20,
                                            20, 20, 20, 20, 20, -1, 1, 0, 64, -64};
  localparam int DIR_PT  [NUM_DIRECTED] = '{40, 40, 40, 40, 40, 40, 40, 30, 30, 9,
                                            10, 70, 71, 0, 255, 128, 127, 85, 11, 69};

  typedef logic [23:0] reg_set_t [NUM_REG_SLOTS];

  typedef enum int {
    CHK_OK,
    CHK_MISMATCH,
    CHK_UNEXPECTED
  } check_e;

  class duty_scoreboard;
    logic [15:0]        center;
    logic [15:0]        left_lock;
    logic [15:0]        right_lock;
    logic [6:0]         band;
    logic [23:0]        kbase;
    logic [23:0]        kquad;
    logic [23:0]        kdiff;
    logic signed [7:0]  last_err;
    logic [15:0]        duty_q[$];

    function new();
      center     = '0;
      left_lock  = '0;
      right_lock = 16'hFFFF;
      band       = 7'd7;
      kbase      = '0;
      kquad      = '0;
      kdiff      = '0;
      last_err   = '0;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [23:0] val);
      case (idx)
        dqgps_pkg::REG_CENTER: center     = val[15:0];
        dqgps_pkg::REG_LEFT:   left_lock  = val[15:0];
        dqgps_pkg::REG_RIGHT:  right_lock = val[15:0];
        dqgps_pkg::REG_DBAND:  band       = val[6:0];
        dqgps_pkg::REG_BASE:   kbase      = val;
        dqgps_pkg::REG_QUAD:   kquad      = val;
        dqgps_pkg::REG_DIFF:   kdiff      = val;
        default: ;
      endcase
    endfunction

    function void note_input(input logic signed [7:0] err, input logic [7:0] pt);
      longint mag, excess, kp, acc, corr, duty, lo, hi;
      mag    = (err < 0) ? -longint'(err) : longint'(err);
      excess = (mag > longint'(band)) ? mag - longint'(band) : 0;
      kp     = longint'(kbase) + excess * excess * longint'(kquad);
      acc    = kp * longint'(err)
             + longint'(kdiff) * (longint'(err) - longint'(last_err)) + HALF_LSB;
      corr   = acc / Q16_ONE;  // truncates toward zero
      last_err = err;
      duty = longint'(center) - corr;
      if (duty < 0) duty = 0;
      if (pt > dqgps_pkg::POINT_RIGHT) duty = longint'(right_lock);
      if (pt < dqgps_pkg::POINT_LEFT)  duty = longint'(left_lock);
      lo = (left_lock < right_lock) ? longint'(left_lock)  : longint'(right_lock);
      hi = (left_lock < right_lock) ? longint'(right_lock) : longint'(left_lock);
      if (duty < lo) duty = lo;
      if (duty > hi) duty = hi;
      duty_q.push_back(duty[15:0]);
    endfunction

    function check_e check_duty(input logic [15:0] got, output logic [15:0] want);
      want = 'x;
      if (duty_q.size() == 0) return CHK_UNEXPECTED;
      want = duty_q.pop_front();
      if (got === want) return CHK_OK;
      return CHK_MISMATCH;
    endfunction

    function int pending();
      return duty_q.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [7:0] lateral_error, [15:8] track_point
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] servo_duty
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i    = '0;
  logic [23:0] cfg_data_i    = '0;

  duty_scoreboard sb = new();
  int          errors        = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_reqs    = 0;
  int          stall_taken   = 0;
  int          stall_left    = 0;
  logic [15:0] want_duty;

  deadband_quadratic_gain_pd_steer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  // receiver: random back-pressure, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_reqs != stall_taken) begin
      stall_taken   <= stall_reqs;
      stall_left    <= STALL_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      case (sb.check_duty(m_axis_tdata, want_duty))
        CHK_MISMATCH:
          report_error($sformatf("servo_duty got %0d want %0d", m_axis_tdata, want_duty));
        CHK_UNEXPECTED:
          report_error($sformatf("servo_duty %0d with no word outstanding", m_axis_tdata));
        default: ;
      endcase
    end
  end

  task automatic write_config(input reg_set_t vals);
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < NUM_REG_SLOTS; i++) begin
      cfg_addr_i <= 3'(i);
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(3'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // valid is left high after a word so back-to-back words need no drop
  task automatic send_word(input logic [7:0] err, input logic [7:0] pt);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pt, err};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(err, pt);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    reg_set_t    vals;
    logic [6:0]  band;
    logic [7:0]  err;
    logic [7:0]  pt;
    logic [23:0] tmp;
    int          mag;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 20;
    recv_idle_pct = 49;

    // register defaults straight out of reset
    send_word(8'd5, 8'd40);
    send_word(8'h80, 8'd40);
    wait_idle();

    vals[dqgps_pkg::REG_CENTER] = 24'h008000;
    vals[dqgps_pkg::REG_LEFT]   = 24'hAB03E8;  // upper bits dropped
    vals[dqgps_pkg::REG_RIGHT]  = 24'h00EA60;
    vals[dqgps_pkg::REG_DBAND]  = 24'h000087;
    vals[dqgps_pkg::REG_BASE]   = 24'h020000;
    vals[dqgps_pkg::REG_QUAD]   = 24'h000800;
    vals[dqgps_pkg::REG_DIFF]   = 24'h010000;
    vals[REG_UNUSED]            = 24'h123456;
    write_config(vals);
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_word(8'(DIR_ERR[i]), 8'(DIR_PT[i]));
    wait_idle();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 49;
      end else if (phase < 6) begin
        send_idle_pct = 49;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (phase)
        PHASE_ALL_ONES: foreach (vals[i]) vals[i] = 24'hFFFFFF;
        PHASE_ALL_ZERO: foreach (vals[i]) vals[i] = '0;
        default: begin
          vals[dqgps_pkg::REG_CENTER] = {8'($urandom), 16'($urandom_range(16000, 50000))};
          vals[dqgps_pkg::REG_LEFT]   = {8'($urandom), 16'($urandom_range(0, 20000))};
          vals[dqgps_pkg::REG_RIGHT]  = {8'($urandom), 16'($urandom_range(45000, 65535))};
          if (phase == PHASE_SWAPPED) begin
            tmp                         = vals[dqgps_pkg::REG_LEFT];
            vals[dqgps_pkg::REG_LEFT]   = vals[dqgps_pkg::REG_RIGHT];
            vals[dqgps_pkg::REG_RIGHT]  = tmp;
          end
          vals[dqgps_pkg::REG_DBAND] = {17'($urandom), 7'($urandom_range(0, 127))};
          vals[dqgps_pkg::REG_BASE]  = ($urandom_range(3) == 0) ? 24'($urandom)
                                        : 24'($urandom_range(0, 24'h3FFFFF));
          vals[dqgps_pkg::REG_QUAD]  = ($urandom_range(3) == 0) ? 24'($urandom)
                                        : 24'($urandom_range(0, 1023));
          vals[dqgps_pkg::REG_DIFF]  = ($urandom_range(3) == 0) ? 24'($urandom)
                                        : 24'($urandom_range(0, 24'h7FFFFF));
        end
      endcase
      vals[REG_UNUSED] = 24'($urandom);
      band = vals[dqgps_pkg::REG_DBAND][6:0];
      write_config(vals);

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (phase == PHASE_SWAPPED && n == STALL_AT_WORD)
          stall_reqs <= stall_reqs + 1;
        if ($urandom_range(4) == 0) begin
          // just either side of the dead band edge
          mag = int'(band) + int'($urandom_range(2)) - 1;
          if (mag < 0) mag = 0;
          err = $urandom_range(1) ? 8'(-mag) : 8'(mag);
        end else begin
          err = 8'($urandom);
        end
        pt = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(10, 70));
        send_word(err, pt);
      end
      wait_idle();
    end

    if (errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
